// File: src/a85_pkg.sv
// ----------------------------------------------------------------------------
// a85_pkg
// Types, character codes and the base-85 power table for the stream decoder.
// ----------------------------------------------------------------------------
package a85_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO5 = 8'h7A;  // 'z'
   localparam logic [7:0] DIGIT_LO   = 8'h21;  // '!'
   localparam logic [7:0] DIGIT_HI   = 8'h75;  // 'u'

   localparam logic [2:0] GROUP_DIGITS = 3'd5;
   localparam logic [2:0] LAST_DIGIT   = 3'd4;

   localparam int POW_WIDTH   = 26;
   localparam int BURST_BYTES = 7;

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_INVALID_CHAR = 2'd1,
      ERR_NO_DIGITS    = 2'd2
   } err_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [1:0] error_code;
      logic       end_of_stream;
      logic       last_of_run;
   } rsp_type;

   // one unit of expansion work: result = operand * 85^power (+ pad)
   typedef struct packed {
      logic [31:0] operand;
      logic [2:0]  power;
      logic        pad_add;
      logic        has_group;
      logic [1:0]  part_bytes;
      err_type     error_code;
      logic        end_of_stream;
   } job_type;

   function automatic logic [POW_WIDTH-1:0] pow85(input logic [2:0] e);
      logic [POW_WIDTH-1:0] p;
      case (e)
         3'd1:    p = POW_WIDTH'(85);
         3'd2:    p = POW_WIDTH'(7225);
         3'd3:    p = POW_WIDTH'(614125);
         3'd4:    p = POW_WIDTH'(52200625);
         default: p = POW_WIDTH'(1);
      endcase
      return p;
   endfunction

endpackage

// File: src/a85_req_if.sv
// ----------------------------------------------------------------------------
// a85_req_if
// Character channel: valid/ready with one character and its end flag.
// ----------------------------------------------------------------------------
interface a85_req_if;
   logic              valid;
   logic              ready;
   a85_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/a85_rsp_if.sv
// ----------------------------------------------------------------------------
// a85_rsp_if
// Result channel: valid/ready with one decoded byte or status result.
// ----------------------------------------------------------------------------
interface a85_rsp_if;
   logic              valid;
   logic              ready;
   a85_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/a85_front.sv
// ----------------------------------------------------------------------------
// a85_front
// Input register, character classification, group accumulator and job register.
// ----------------------------------------------------------------------------
module a85_front (
   input  logic              clock,
   input  logic              reset,
   a85_req_if.sink           req_chan,
   output logic              job_valid,
   input  logic              job_ready,
   output a85_pkg::job_type  job
);

   logic              in_valid_ff, in_valid_in;
   a85_pkg::req_type  in_data_ff;
   logic [31:0]       group_ff, group_in;
   logic [2:0]        count_ff, count_in;
   logic              seen_ff, seen_in;
   logic              failed_ff, failed_in;
   logic              job_valid_ff, job_valid_in;
   a85_pkg::job_type  job_ff, job_in;

   logic        is_skip, is_z, is_digit, is_bad, stream_end, emit;
   logic        job_take, in_adv, req_fire;
   logic [7:0]  digit;
   logic [31:0] group_x85;

   assign job_take = !job_valid_ff || job_ready;
   assign in_adv   = in_valid_ff && (!emit || job_take);
   assign req_chan.ready = !in_valid_ff || in_adv;
   assign req_fire = req_chan.valid && req_chan.ready;

   assign stream_end = in_data_ff.stream_end;
   assign is_skip  = in_data_ff.char_in == a85_pkg::CHAR_SPACE
                  || in_data_ff.char_in == a85_pkg::CHAR_LF
                  || in_data_ff.char_in == a85_pkg::CHAR_CR;
   assign is_z     = in_data_ff.char_in == a85_pkg::CHAR_ZERO5;
   assign is_digit = in_data_ff.char_in >= a85_pkg::DIGIT_LO
                  && in_data_ff.char_in <= a85_pkg::DIGIT_HI;
   assign is_bad   = !is_skip && !is_z && !is_digit;
   assign digit    = in_data_ff.char_in - a85_pkg::DIGIT_LO;

   // g*85 + d as shift-add, mod 2^32
   assign group_x85 = (group_ff << 6) + (group_ff << 4) + (group_ff << 2) + group_ff
                    + {24'd0, digit};

   always_comb begin
      group_in  = group_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      failed_in = failed_ff;

      job_in               = '0;
      job_in.operand       = group_ff;
      job_in.error_code    = a85_pkg::ERR_NONE;
      job_in.end_of_stream = stream_end;

      if (!failed_ff) begin
         if (is_z) begin
            seen_in          = 1'b1;
            group_in         = '0;
            job_in.has_group = 1'b1;
            job_in.power     = (count_ff == 3'd0) ? 3'd0 : a85_pkg::GROUP_DIGITS - count_ff;
            if (count_ff != 3'd0) begin
               job_in.part_bytes = 2'(count_ff - 3'd1);
            end
         end else if (is_digit) begin
            seen_in        = 1'b1;
            job_in.operand = group_x85;
            if (count_ff == a85_pkg::LAST_DIGIT) begin
               group_in         = '0;
               count_in         = '0;
               job_in.has_group = 1'b1;
            end else begin
               group_in          = group_x85;
               count_in          = count_ff + 3'd1;
               job_in.power      = a85_pkg::LAST_DIGIT - count_ff;
               job_in.pad_add    = 1'b1;
               job_in.part_bytes = 2'(count_ff);
            end
         end else if (is_skip) begin
            if (count_ff != 3'd0) begin
               job_in.power      = a85_pkg::GROUP_DIGITS - count_ff;
               job_in.pad_add    = 1'b1;
               job_in.part_bytes = 2'(count_ff - 3'd1);
            end
         end else begin
            failed_in         = 1'b1;
            job_in.error_code = a85_pkg::ERR_INVALID_CHAR;
         end
      end else if (stream_end) begin
         job_in.error_code = a85_pkg::ERR_INVALID_CHAR;
      end

      if (!stream_end) begin
         job_in.part_bytes = '0;
      end else if (!failed_ff && !is_bad && !seen_ff && !is_z && !is_digit) begin
         job_in.error_code = a85_pkg::ERR_NO_DIGITS;
      end

      emit = job_in.has_group || stream_end || job_in.error_code != a85_pkg::ERR_NONE;

      if (stream_end) begin
         group_in  = '0;
         count_in  = '0;
         seen_in   = 1'b0;
         failed_in = 1'b0;
      end
   end

   always_comb begin
      in_valid_in  = req_fire ? 1'b1 : (in_adv ? 1'b0 : in_valid_ff);
      job_valid_in = job_take ? (in_adv && emit) : job_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         job_valid_ff <= 1'b0;
         group_ff     <= '0;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         failed_ff    <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         job_valid_ff <= job_valid_in;
         if (in_adv) begin
            group_ff  <= group_in;
            count_ff  <= count_in;
            seen_ff   <= seen_in;
            failed_ff <= failed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_chan.payload;
      end
      if (in_adv && emit) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// File: src/a85_burst.sv
// ----------------------------------------------------------------------------
// a85_burst
// Multiplies out one job into up to seven bytes and hands them out in order.
// ----------------------------------------------------------------------------
module a85_burst (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  a85_pkg::job_type  job,
   a85_rsp_if.source         rsp_chan
);

   localparam int BYTES_W = 8 * a85_pkg::BURST_BYTES;

   logic                  burst_valid_ff, burst_valid_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [2:0]            remain_ff, remain_in;
   logic                  byte_mode_ff, byte_mode_in;
   a85_pkg::err_type      error_ff, error_in;
   logic                  eos_ff, eos_in;

   logic [a85_pkg::POW_WIDTH-1:0]    pow;
   logic [a85_pkg::POW_WIDTH+31:0]   prod;
   logic [31:0]                      pad, word, part;
   logic [2:0]                       nbytes;
   logic                             last, rsp_fire, load;

   assign pow  = a85_pkg::pow85(job.power);
   assign prod = job.operand * pow;
   assign pad  = {{(32-a85_pkg::POW_WIDTH){1'b0}}, pow} - 32'd1;
   assign word = prod[31:0] + (job.pad_add ? pad : 32'd0);
   assign part = job.pad_add ? word : pad;
   assign nbytes = {job.has_group, 2'b00} + {1'b0, job.part_bytes};

   assign last      = remain_ff == 3'd1;
   assign rsp_fire  = burst_valid_ff && rsp_chan.ready;
   assign job_ready = !burst_valid_ff || (rsp_fire && last);
   assign load      = job_valid && job_ready;

   always_comb begin
      burst_valid_in = burst_valid_ff;
      bytes_in       = bytes_ff;
      remain_in      = remain_ff;
      byte_mode_in   = byte_mode_ff;
      error_in       = error_ff;
      eos_in         = eos_ff;
      if (load) begin
         burst_valid_in = 1'b1;
         bytes_in       = job.has_group ? {word, part[31:8]} : {part[31:8], 32'd0};
         remain_in      = (nbytes == 3'd0) ? 3'd1 : nbytes;
         byte_mode_in   = nbytes != 3'd0;
         error_in       = job.error_code;
         eos_in         = job.end_of_stream;
      end else if (rsp_fire) begin
         if (last) begin
            burst_valid_in = 1'b0;
         end else begin
            bytes_in  = bytes_ff << 8;
            remain_in = remain_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_valid_ff <= 1'b0;
         remain_ff      <= '0;
      end else begin
         burst_valid_ff <= burst_valid_in;
         remain_ff      <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff     <= bytes_in;
      byte_mode_ff <= byte_mode_in;
      error_ff     <= error_in;
      eos_ff       <= eos_in;
   end

   always_comb begin
      rsp_chan.valid                 = burst_valid_ff;
      rsp_chan.payload.data_byte     = byte_mode_ff ? bytes_ff[BYTES_W-1 -: 8] : 8'd0;
      rsp_chan.payload.byte_valid    = byte_mode_ff;
      rsp_chan.payload.error_code    = byte_mode_ff ? a85_pkg::ERR_NONE : error_ff;
      rsp_chan.payload.end_of_stream = eos_ff && last;
      rsp_chan.payload.last_of_run   = last;
   end

endmodule

// File: src/ascii85_stream_decoder.sv
// ----------------------------------------------------------------------------
// ascii85_stream_decoder
// Base-85 text decoder: one character per transaction in, decoded bytes out.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                      | handshake
//  req_chan  | in  | char_in[7:0], stream_end                     | valid/ready
//  rsp_chan  | out | data_byte[7:0], byte_valid, error_code[1:0], | valid/ready
//            |     | end_of_stream, last_of_run                   |
//
//  A character enters the input register, is decoded into the job register
//  and multiplied out into the burst register. Characters that give no
//  result are taken every cycle; a character that gives n results (up to
//  seven) holds the result side until all n of them have been taken.
//  The group multiply by 85^k sits alone between job and burst registers.
//  Synchronous reset clears all handshake and accumulator state.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   a85_req_if.sink     req_chan,
   a85_rsp_if.source   rsp_chan
);

   logic              job_valid;
   logic              job_ready;
   a85_pkg::job_type  job;

   a85_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job)
   );

   a85_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (job),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.end_of_stream |-> rsp_chan.payload.last_of_run)
      else $error("end_of_stream without last_of_run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.payload.byte_valid
         |-> rsp_chan.payload.error_code == a85_pkg::ERR_NONE)
      else $error("byte result carries an error code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.payload.byte_valid |-> rsp_chan.payload.last_of_run)
      else $error("status result is not the last of its run");

   assert property (@(posedge clock) disable iff (reset)
      job_valid && !job_ready |=> job_valid && $stable(job))
      else $error("job dropped or changed while stalled");
`endif

endmodule
